@@ hdl/atc_pkg.sv @@
// shared constants, register indexes and the cordic arctangent table
// used by the calibration lanes, the cordic pipelines and the top level
`default_nettype none
package atc_pkg;

	localparam int RAW_W   = 13;
	localparam int OFS_W   = 14;
	localparam int GAIN_W  = 16;
	localparam int SH_W    = 2;
	localparam int G_W     = 17;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	// cordic operand and accumulator widths
	localparam int CIN_W   = 26;
	localparam int CX_W    = 36;
	localparam int CZ_W    = 26;
	localparam int CORDIC_STEPS = 20;
	localparam int ANG_W   = 16;

	// square root pipeline input width (radicand shifted up by 16)
	localparam int SQ_W    = 50;

	localparam int ASIN_LIM = 11520;
	localparam int ROLL_LIM = 23040;
	localparam int QUARTER  = 5760;
	localparam int Z180     = 5898240;

	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4089;

	localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_X   = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN_Y   = 3'd4;
	localparam logic [IDX_W-1:0] REG_GAIN_Z   = 3'd5;
	localparam logic [IDX_W-1:0] REG_RANGE    = 3'd6;

	localparam logic [2:0] ORI_Z_UP   = 3'd0;
	localparam logic [2:0] ORI_Z_DOWN = 3'd1;
	localparam logic [2:0] ORI_Y_UP   = 3'd2;
	localparam logic [2:0] ORI_Y_DOWN = 3'd3;
	localparam logic [2:0] ORI_X_UP   = 3'd4;
	localparam logic [2:0] ORI_X_DOWN = 3'd5;

	// atan(2^-i) in 1/32768 degree
	function automatic logic signed [CZ_W-1:0] atc_atan(input logic [4:0] i);
		logic signed [CZ_W-1:0] t;
		unique case (i)
			5'd0:  t = 26'sd1474560;
			5'd1:  t = 26'sd870484;
			5'd2:  t = 26'sd459940;
			5'd3:  t = 26'sd233473;
			5'd4:  t = 26'sd117189;
			5'd5:  t = 26'sd58652;
			5'd6:  t = 26'sd29333;
			5'd7:  t = 26'sd14667;
			5'd8:  t = 26'sd7334;
			5'd9:  t = 26'sd3667;
			5'd10: t = 26'sd1833;
			5'd11: t = 26'sd917;
			5'd12: t = 26'sd458;
			5'd13: t = 26'sd229;
			5'd14: t = 26'sd115;
			5'd15: t = 26'sd57;
			5'd16: t = 26'sd29;
			5'd17: t = 26'sd14;
			5'd18: t = 26'sd7;
			5'd19: t = 26'sd4;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

@@ hdl/accel_calibrate_tilt_orientation_unit.sv @@
// accelerometer calibration, tilt angles and orientation class, top level
// uses atc_pkg, atc_lane, atc_isqrt and atc_cordic
//
// Input channel: in_valid/in_stall carry one raw x/y/z sample per transfer.
// Output channel: out_valid/out_stall carry g per axis, asin tilt per axis,
// pitch, roll and the orientation class for each sample, in order.
// Configuration: wr_en/wr_index/wr_data write one register per clock edge;
// the user writes only while no sample is in flight; the block does not check.
// Pipeline: 3 calibration stages, 2 squaring stages, 25 square root stages,
// 22 cordic stages, then the output register.
// Throughput: one sample per cycle while not stalled; three calibration
// lanes, four square root pipelines and five cordic pipelines run side by
// side, and a final stage merges the angles into the orientation class.
// Reset: clears pipeline valid bits and the output valid; offsets go to 0,
// gains to 4089 and the range shift to 0.
// Receiver stall: the output register holds; the pipeline keeps moving
// while its last stage is empty and stalls input only when its last stage is full.
`default_nettype none
module accel_calibrate_tilt_orientation_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [atc_pkg::RAW_W-1:0]    raw_x,
	input  wire logic signed [atc_pkg::RAW_W-1:0]    raw_y,
	input  wire logic signed [atc_pkg::RAW_W-1:0]    raw_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [16:0]                       g_x,
	output logic signed [16:0]                       g_y,
	output logic signed [16:0]                       g_z,
	output logic signed [14:0]                       angle_x,
	output logic signed [14:0]                       angle_y,
	output logic signed [14:0]                       angle_z,
	output logic signed [14:0]                       pitch,
	output logic signed [15:0]                       roll,
	output logic        [2:0]                        orientation,
	input  wire logic                                wr_en,
	input  wire logic [atc_pkg::IDX_W-1:0]           wr_index,
	input  wire logic [atc_pkg::CFG_W-1:0]           wr_data
);
	import atc_pkg::*;

	localparam int L     = 52;
	localparam int SQ_D  = SQ_W / 2;
	localparam int C_D   = SQ_D;
	localparam int G_D   = L - 5;

	logic signed [OFS_W-1:0]  offset_q [3];
	logic        [GAIN_W-1:0] gain_q [3];
	logic        [SH_W-1:0]   range_q;

	logic [L-1:0] vld_q;
	logic         adv;

	logic signed [RAW_W-1:0] raw [3];
	logic signed [G_W-1:0]   g_l [3];

	logic signed [13:0]      c [3];
	logic signed [27:0]      csq [3];
	logic signed [33:0]      sqy;
	logic signed [33:0]      sqz;

	logic signed [G_W-1:0]   g_s4 [3];
	logic signed [13:0]      c_s4 [3];
	logic        [24:0]      hsq_s4 [3];
	logic        [32:0]      sqy_s4;
	logic        [32:0]      sqz_s4;

	logic signed [G_W-1:0]   g_s5 [3];
	logic signed [13:0]      c_s5 [3];
	logic        [24:0]      hsq_s5 [3];
	logic        [33:0]      msum_s5;

	logic [3*G_W-1:0] g_dl [G_D];
	logic [3*14-1:0]  c_dl [C_D];

	logic [SQ_D-1:0]         h_root [3];
	logic [SQ_D-1:0]         r_root;

	logic signed [CIN_W-1:0] asin_y [3];
	logic signed [17:0]      ngx;
	logic signed [G_W-1:0]   gy_d;
	logic signed [G_W-1:0]   gz_d;
	logic signed [ANG_W-1:0] ang [3];
	logic signed [ANG_W-1:0] pitch_a;
	logic signed [ANG_W-1:0] roll_a;
	logic [2:0]              ori;

	logic signed [16:0] g_x_q, g_y_q, g_z_q;
	logic signed [14:0] ax_q, ay_q, az_q, pitch_q;
	logic signed [15:0] roll_q;
	logic [2:0]         ori_q;
	logic               out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				offset_q[k] <= '0;
				gain_q[k]   <= GAIN_RST;
			end
			range_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OFFSET_X: offset_q[0] <= wr_data[OFS_W-1:0];
				REG_OFFSET_Y: offset_q[1] <= wr_data[OFS_W-1:0];
				REG_OFFSET_Z: offset_q[2] <= wr_data[OFS_W-1:0];
				REG_GAIN_X:   gain_q[0]   <= wr_data;
				REG_GAIN_Y:   gain_q[1]   <= wr_data;
				REG_GAIN_Z:   gain_q[2]   <= wr_data;
				REG_RANGE:    range_q     <= wr_data[SH_W-1:0];
				default: ;
			endcase
		end
	end

	// the whole pipeline moves unless its last item cannot leave
	assign adv      = !(vld_q[L-1] && out_valid_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[L-2:0], in_valid};
	end

	assign raw[0] = raw_x;
	assign raw[1] = raw_y;
	assign raw[2] = raw_z;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		atc_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.raw    (raw[k]),
			.offset (offset_q[k]),
			.gain   (gain_q[k]),
			.shift  (range_q),
			.g      (g_l[k])
		);

		always_comb begin
			if (g_l[k] > 17'sd4096)
				c[k] = 14'sd4096;
			else if (g_l[k] < -17'sd4096)
				c[k] = -14'sd4096;
			else
				c[k] = g_l[k][13:0];
		end
		assign csq[k] = c[k] * c[k];

		always_ff @(posedge clk) begin
			if (adv) begin
				g_s4[k]   <= g_l[k];
				c_s4[k]   <= c[k];
				hsq_s4[k] <= 25'(28'sd16777216 - csq[k]);
				g_s5[k]   <= g_s4[k];
				c_s5[k]   <= c_s4[k];
				hsq_s5[k] <= hsq_s4[k];
			end
		end

		atc_isqrt #(.W(SQ_W)) u_hsqrt (
			.clk      (clk),
			.en       (adv),
			.radicand ({9'b0, hsq_s5[k], 16'b0}),
			.root     (h_root[k])
		);

		assign asin_y[k] = {{4{c_dl[C_D-1][14*k+13]}}, c_dl[C_D-1][14*k +: 14], 8'b0};

		atc_cordic #(.LIM(ASIN_LIM)) u_asin (
			.clk   (clk),
			.en    (adv),
			.y_in  (asin_y[k]),
			.x_in  ({1'b0, h_root[k]}),
			.angle (ang[k])
		);
	end

	assign sqy = g_l[1] * g_l[1];
	assign sqz = g_l[2] * g_l[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			sqy_s4  <= sqy[32:0];
			sqz_s4  <= sqz[32:0];
			msum_s5 <= 34'(sqy_s4) + 34'(sqz_s4);
		end
	end

	atc_isqrt #(.W(SQ_W)) u_rsqrt (
		.clk      (clk),
		.en       (adv),
		.radicand ({msum_s5, 16'b0}),
		.root     (r_root)
	);

	// sideband delay lines that follow the square root and cordic stages
	always_ff @(posedge clk) begin
		if (adv) begin
			g_dl[0] <= {g_s5[2], g_s5[1], g_s5[0]};
			c_dl[0] <= {c_s5[2], c_s5[1], c_s5[0]};
			for (int k = 1; k < G_D; k++)
				g_dl[k] <= g_dl[k-1];
			for (int k = 1; k < C_D; k++)
				c_dl[k] <= c_dl[k-1];
		end
	end

	// taps at the square root output feed pitch and roll
	assign ngx  = -18'($signed(g_dl[C_D-1][G_W-1:0]));
	assign gy_d = $signed(g_dl[C_D-1][2*G_W-1:G_W]);
	assign gz_d = $signed(g_dl[C_D-1][3*G_W-1:2*G_W]);

	atc_cordic #(.LIM(ASIN_LIM)) u_pitch (
		.clk   (clk),
		.en    (adv),
		.y_in  ({ngx, 8'b0}),
		.x_in  ({1'b0, r_root}),
		.angle (pitch_a)
	);

	atc_cordic #(.LIM(ROLL_LIM)) u_roll (
		.clk   (clk),
		.en    (adv),
		.y_in  (CIN_W'(gy_d)),
		.x_in  (CIN_W'(gz_d)),
		.angle (roll_a)
	);

	// merge the lane angles into the orientation class
	always_comb begin
		priority if (ang[0] > -16'sd5760 && ang[0] < 16'sd5760) begin
			if (ang[1] > -16'sd5760 && ang[1] < 16'sd5760)
				ori = (ang[2] > 0) ? ORI_Z_UP : ORI_Z_DOWN;
			else
				ori = (ang[1] > 0) ? ORI_Y_UP : ORI_Y_DOWN;
		end else begin
			ori = (ang[0] > 0) ? ORI_X_UP : ORI_X_DOWN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[L-1]) begin
			g_x_q   <= $signed(g_dl[G_D-1][G_W-1:0]);
			g_y_q   <= $signed(g_dl[G_D-1][2*G_W-1:G_W]);
			g_z_q   <= $signed(g_dl[G_D-1][3*G_W-1:2*G_W]);
			ax_q    <= ang[0][14:0];
			ay_q    <= ang[1][14:0];
			az_q    <= ang[2][14:0];
			pitch_q <= pitch_a[14:0];
			roll_q  <= roll_a;
			ori_q   <= ori;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && vld_q[L-1])
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid   = out_valid_q;
	assign g_x         = g_x_q;
	assign g_y         = g_y_q;
	assign g_z         = g_z_q;
	assign angle_x     = ax_q;
	assign angle_y     = ay_q;
	assign angle_z     = az_q;
	assign pitch       = pitch_q;
	assign roll        = roll_q;
	assign orientation = ori_q;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_q[L-1] && out_valid_q && out_stall))
		else $error("input stalled while pipeline tail can move");

	a_tail_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[L-1] && !in_stall) |=> out_valid)
		else $error("pipeline tail item lost");

	a_ori_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (orientation == ORI_Z_UP || orientation == ORI_Z_DOWN ||
			orientation == ORI_Y_UP || orientation == ORI_Y_DOWN ||
			orientation == ORI_X_UP || orientation == ORI_X_DOWN))
		else $error("orientation class out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll >= -16'sd23040 && roll <= 16'sd23040))
		else $error("roll outside clamp range");

endmodule
`default_nettype wire

@@ hdl/atc_lane.sv @@
// one axis lane: offset correction, gain multiply, rounding and saturation
// three pipeline stages; depends on atc_pkg
`default_nettype none
module atc_lane (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [atc_pkg::RAW_W-1:0]  raw,
	input  wire logic signed [atc_pkg::OFS_W-1:0]  offset,
	input  wire logic        [atc_pkg::GAIN_W-1:0] gain,
	input  wire logic        [atc_pkg::SH_W-1:0]   shift,
	output logic signed      [atc_pkg::G_W-1:0]    g
);
	import atc_pkg::*;

	logic signed [OFS_W-1:0]  offs;
	logic signed [14:0]       corr;
	logic signed [14:0]       corr_s1;
	logic        [GAIN_W-1:0] gain_s1;
	logic        [SH_W-1:0]   sh_s1;
	logic signed [31:0]       prod_s2;
	logic        [SH_W-1:0]   sh_s2;
	logic signed [34:0]       v;
	logic signed [34:0]       vr;
	logic signed [26:0]       t;
	logic signed [G_W-1:0]    g_s3;

	assign offs = offset >>> shift;
	assign corr = 15'(raw) - 15'(offs);

	// scale by the range factor, round at bit 8
	assign v  = 35'(prod_s2) <<< sh_s2;
	assign vr = v + 35'sd128;
	assign t  = vr[34:8];

	always_ff @(posedge clk) begin
		if (en) begin
			corr_s1 <= corr;
			gain_s1 <= gain;
			sh_s1   <= shift;
			prod_s2 <= corr_s1 * $signed({1'b0, gain_s1});
			sh_s2   <= sh_s1;
			if (t > 27'sd65535)
				g_s3 <= 17'sd65535;
			else if (t < -27'sd65536)
				g_s3 <= -17'sd65536;
			else
				g_s3 <= t[G_W-1:0];
		end
	end

	assign g = g_s3;

endmodule
`default_nettype wire

@@ hdl/atc_isqrt.sv @@
// pipelined integer square root, one result bit per stage
// self-contained; radicand width W is even, root has W/2 bits
`default_nettype none
module atc_isqrt #(
	parameter int W = 50
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [W-1:0]     radicand,
	output logic      [W/2-1:0]   root
);
	localparam int R = W / 2;

	logic [R+1:0] rem_q  [R];
	logic [R-1:0] root_q [R];
	logic [W-1:0] n_q    [R];

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic [R+1:0] rem_in;
		logic [R-1:0] root_in;
		logic [W-1:0] n_in;
		logic [R+1:0] cur;
		logic [R+1:0] trial;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign n_in    = radicand;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign n_in    = n_q[k-1];
		end

		// bring down the next two radicand bits and try a one
		assign cur   = {rem_in[R-1:0], n_in[W-1:W-2]};
		assign trial = {root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? cur - trial : cur;
				root_q[k] <= {root_in[R-2:0], ge};
				n_q[k]    <= n_in << 2;
			end
		end
	end

	assign root = root_q[R-1];

endmodule
`default_nettype wire

@@ hdl/atc_cordic.sv @@
// pipelined vectoring cordic atan2 with quadrant fold, rounding and clamp
// 22 stages; depends on atc_pkg for widths and the arctangent table
`default_nettype none
module atc_cordic #(
	parameter int LIM = 11520
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [atc_pkg::CIN_W-1:0]  y_in,
	input  wire logic signed [atc_pkg::CIN_W-1:0]  x_in,
	output logic signed      [atc_pkg::ANG_W-1:0]  angle
);
	import atc_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic signed [CX_W-1:0] x_q [N+1];
	logic signed [CX_W-1:0] y_q [N+1];
	logic signed [CZ_W-1:0] z_q [N+1];
	logic                   zero_q [N+1];

	logic signed [CX_W-1:0] xw;
	logic signed [CX_W-1:0] yw;
	logic                   neg;
	logic signed [CZ_W-1:0] z0;
	logic signed [CZ_W-1:0] zr;
	logic signed [17:0]     zs;
	logic signed [ANG_W-1:0] angle_q;

	assign neg = x_in[CIN_W-1];
	assign xw  = CX_W'(x_in);
	assign yw  = CX_W'(y_in);

	// left half plane: fold over and start the accumulator at +-180
	always_comb begin
		if (!neg)
			z0 = '0;
		else if (y_in[CIN_W-1])
			z0 = -CZ_W'(Z180);
		else
			z0 = CZ_W'(Z180);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= (neg ? -xw : xw) <<< 8;
			y_q[0]    <= (neg ? -yw : yw) <<< 8;
			z_q[0]    <= z0;
			zero_q[0] <= (x_in == '0) && (y_in == '0);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [CX_W-1:0] xs;
		logic signed [CX_W-1:0] ys;
		logic signed [CZ_W-1:0] ta;

		assign xs = x_q[i] >>> i;
		assign ys = y_q[i] >>> i;
		assign ta = atc_atan(5'(i));

		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
				if (y_q[i] > 0) begin
					x_q[i+1] <= x_q[i] + ys;
					y_q[i+1] <= y_q[i] - xs;
					z_q[i+1] <= z_q[i] + ta;
				end else begin
					x_q[i+1] <= x_q[i] - ys;
					y_q[i+1] <= y_q[i] + xs;
					z_q[i+1] <= z_q[i] - ta;
				end
			end
		end
	end

	assign zr = z_q[N] + CZ_W'(128);
	assign zs = zr[CZ_W-1:8];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_q[N])
				angle_q <= '0;
			else if (zs > 18'(LIM))
				angle_q <= ANG_W'(LIM);
			else if (zs < -18'(LIM))
				angle_q <= -ANG_W'(LIM);
			else
				angle_q <= zs[ANG_W-1:0];
		end
	end

	assign angle = angle_q;

endmodule
`default_nettype wire
